>>> hw/rtl/btmx_pkg.sv
`default_nettype none

package btmx_pkg;

    localparam int KEY_BITS    = 31;
    localparam int POOL_NODES  = 65536;
    localparam int COUNT_BITS  = 32;
    localparam int DELTA_BITS  = 16;
    localparam int STATUS_BITS = 3;
    localparam int NODE_BITS   = $clog2(POOL_NODES);
    localparam int FREE_BITS   = NODE_BITS + 1;
    localparam int DEPTH_BITS  = $clog2(KEY_BITS + 1);

    localparam logic CMD_QUERY = 1'b1;

    typedef logic [NODE_BITS-1:0]  node_idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [DEPTH_BITS-1:0] depth_t;

    typedef struct packed {
        node_idx_t left;
        node_idx_t right;
        count_t    count;
    } node_t;

    typedef struct packed {
        logic      en;
        node_idx_t addr;
        node_t     data;
    } node_wr_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_ABSENT = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_OVER   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DECIDE,
        S_APPLY,
        S_ALLOC,
        S_QWALK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/btmx_node_ram.sv
`default_nettype none

module btmx_node_ram
(
    input  logic                clk,
    input  btmx_pkg::node_wr_t  wr,
    input  btmx_pkg::node_idx_t rd_addr_a,
    input  btmx_pkg::node_idx_t rd_addr_b,
    output btmx_pkg::node_t     rd_data_a,
    output btmx_pkg::node_t     rd_data_b
);
    import btmx_pkg::*;

    node_t mem [POOL_NODES];
    node_t rd_a_reg;
    node_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

>>> hw/rtl/binary_trie_max_xor.sv
// A query reads one node pair per level down the trie, then issues its result; a query on
// an empty set issues its result at once.
// An update does a check walk down to the depth where its path ends (0 to 31), a decision,
// a write-back walk and one new node per missing level; a refused one ends at the decision.
// One item in work; the next beat is taken once the result is issued, even while it waits.
// Reset: asynchronous, clears root and control, free pointer to 1; pool entries undefined.
`default_nettype none

module binary_trie_max_xor
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [btmx_pkg::KEY_BITS-1:0]         value,
    input  logic signed [btmx_pkg::DELTA_BITS-1:0] delta,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [btmx_pkg::KEY_BITS-1:0]         max_xor,
    output logic [btmx_pkg::STATUS_BITS-1:0]      status
);
    import btmx_pkg::*;

    state_t                   state_reg, state_next;
    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic                     neg_reg, neg_next;
    logic [DELTA_BITS-1:0]    mag_reg, mag_next;
    node_idx_t                node_reg, node_next;
    depth_t                   depth_reg, depth_next;
    depth_t                   found_reg, found_next;
    logic                     bad_reg, bad_next;
    logic [FREE_BITS-1:0]     free_reg, free_next;
    logic [KEY_BITS-1:0]      acc_reg, acc_next;
    node_idx_t                cl_reg, cl_next;
    node_idx_t                cr_reg, cr_next;
    node_t                    root_reg, root_next;
    status_t                  res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0]      max_xor_reg, max_xor_next;
    status_t                  status_reg, status_next;

    node_wr_t                 wr;
    node_idx_t                rd_addr_a, rd_addr_b;
    node_t                    rd_a, rd_b;

    logic                     in_fire, out_fire;
    node_t                    cur;
    logic [KEY_BITS:0]        key_ext;
    depth_t                   bit_idx;
    logic                     key_bit, at_leaf, at_found;
    node_idx_t                child;
    logic [COUNT_BITS:0]      count_sum;
    logic                     bad_now;
    count_t                   count_upd;
    node_idx_t                o_ptr, s_ptr;
    node_t                    o_e, s_e;
    logic                     take;
    node_idx_t                q_left, q_right;
    logic [KEY_BITS:0]        acc_ext;
    depth_t                   missing;
    logic [FREE_BITS:0]       free_need;
    logic                     pool_short;
    logic                     upd_fail;
    node_idx_t                new_idx;
    node_t                    upd_node, new_node;

    btmx_node_ram u_ram
    (
        .clk       (clk),
        .wr        (wr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign max_xor   = max_xor_reg;
    assign status    = status_reg;

    always_comb
    begin
        cur       = (node_reg == '0) ? root_reg : rd_a;
        key_ext   = {key_reg, 1'b0};
        bit_idx   = DEPTH_BITS'(KEY_BITS) - depth_reg;
        key_bit   = key_ext[bit_idx];
        at_leaf   = (depth_reg == DEPTH_BITS'(KEY_BITS));
        at_found  = (depth_reg == found_reg);
        child     = key_bit ? cur.right : cur.left;
        count_sum = {1'b0, cur.count} + (COUNT_BITS + 1)'(mag_reg);
        bad_now   = neg_reg ? (cur.count < COUNT_BITS'(mag_reg)) : count_sum[COUNT_BITS];
        count_upd = neg_reg ? (cur.count - COUNT_BITS'(mag_reg)) : count_sum[COUNT_BITS-1:0];

        o_ptr = key_bit ? cl_reg : cr_reg;
        s_ptr = key_bit ? cr_reg : cl_reg;
        o_e   = key_bit ? rd_a : rd_b;
        s_e   = key_bit ? rd_b : rd_a;
        take  = (o_ptr != '0) && (o_e.count != '0);
        if (take)
        begin
            q_left  = o_e.left;
            q_right = o_e.right;
        end
        else if (s_ptr != '0)
        begin
            q_left  = s_e.left;
            q_right = s_e.right;
        end
        else
        begin
            q_left  = root_reg.left;
            q_right = root_reg.right;
        end
        acc_ext          = {acc_reg, 1'b0};
        acc_ext[bit_idx] = take;

        missing    = DEPTH_BITS'(KEY_BITS) - found_reg;
        free_need  = {1'b0, free_reg} + (FREE_BITS + 1)'(missing);
        pool_short = (free_need > (FREE_BITS + 1)'(POOL_NODES));
        upd_fail   = neg_reg ? ((missing != '0) || bad_reg) : (bad_reg || pool_short);
        new_idx    = free_reg[NODE_BITS-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == CMD_QUERY)
                    begin
                        state_next = (root_reg.count == '0) ? S_DONE : S_QWALK;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (at_leaf || (child == '0))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = upd_fail ? S_DONE : S_APPLY;
            end
            S_APPLY:
            begin
                if (at_found)
                begin
                    state_next = at_leaf ? S_DONE : S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (at_leaf)
                begin
                    state_next = S_DONE;
                end
            end
            S_QWALK:
            begin
                if (depth_reg == DEPTH_BITS'(KEY_BITS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        key_next       = key_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        node_next      = node_reg;
        depth_next     = depth_reg;
        found_next     = found_reg;
        bad_next       = bad_reg;
        free_next      = free_reg;
        acc_next       = acc_reg;
        cl_next        = cl_reg;
        cr_next        = cr_reg;
        root_next      = root_reg;
        res_next       = res_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        max_xor_next   = max_xor_reg;
        status_next    = status_reg;
        wr             = '0;
        rd_addr_a      = child;
        rd_addr_b      = '0;
        upd_node       = cur;
        new_node       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr_a = root_reg.left;
                rd_addr_b = root_reg.right;
                if (in_fire)
                begin
                    key_next   = value;
                    neg_next   = delta[DELTA_BITS-1];
                    mag_next   = delta[DELTA_BITS-1] ? DELTA_BITS'(~delta + 1'b1)
                                                     : DELTA_BITS'(delta);
                    node_next  = '0;
                    depth_next = '0;
                    bad_next   = 1'b0;
                    acc_next   = '0;
                    cl_next    = root_reg.left;
                    cr_next    = root_reg.right;
                    res_next   = ((command == CMD_QUERY) && (root_reg.count == '0))
                                 ? ST_EMPTY : ST_OK;
                end
            end
            S_CHECK:
            begin
                bad_next = bad_reg || bad_now;
                if (at_leaf || (child == '0))
                begin
                    found_next = depth_reg;
                end
                else
                begin
                    node_next  = child;
                    depth_next = depth_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                node_next  = '0;
                depth_next = '0;
                if (neg_reg)
                begin
                    res_next = upd_fail ? ST_ABSENT : ST_OK;
                end
                else if (bad_reg)
                begin
                    res_next = ST_OVER;
                end
                else
                begin
                    res_next = pool_short ? ST_FULL : ST_OK;
                end
            end
            S_APPLY:
            begin
                upd_node.count = count_upd;
                // hang the first new node off the last existing one
                if (at_found && !at_leaf)
                begin
                    if (key_bit)
                    begin
                        upd_node.right = new_idx;
                    end
                    else
                    begin
                        upd_node.left = new_idx;
                    end
                end
                if (node_reg == '0)
                begin
                    root_next = upd_node;
                end
                else
                begin
                    wr.en   = 1'b1;
                    wr.addr = node_reg;
                    wr.data = upd_node;
                end
                depth_next = depth_reg + 1'b1;
                if (!at_found)
                begin
                    node_next = child;
                end
            end
            S_ALLOC:
            begin
                new_node.count = COUNT_BITS'(mag_reg);
                if (!at_leaf)
                begin
                    if (key_bit)
                    begin
                        new_node.right = new_idx + 1'b1;
                    end
                    else
                    begin
                        new_node.left = new_idx + 1'b1;
                    end
                end
                wr.en      = 1'b1;
                wr.addr    = new_idx;
                wr.data    = new_node;
                free_next  = free_reg + 1'b1;
                depth_next = depth_reg + 1'b1;
            end
            S_QWALK:
            begin
                rd_addr_a  = q_left;
                rd_addr_b  = q_right;
                cl_next    = q_left;
                cr_next    = q_right;
                acc_next   = acc_ext[KEY_BITS:1];
                depth_next = depth_reg + 1'b1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    max_xor_next   = acc_reg;
                    status_next    = res_reg;
                end
            end
            default:
            begin
                rd_addr_a = child;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= FREE_BITS'(1);
            root_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        node_reg    <= node_next;
        depth_reg   <= depth_next;
        found_reg   <= found_next;
        bad_reg     <= bad_next;
        acc_reg     <= acc_next;
        cl_reg      <= cl_next;
        cr_reg      <= cr_next;
        res_reg     <= res_next;
        max_xor_reg <= max_xor_next;
        status_reg  <= status_next;
    end

endmodule

`default_nettype wire
